>>> sv/i2cmts_pkg.sv
`default_nettype none

package i2cmts_pkg;

    // Host command codes
    typedef enum logic [2:0] {
        CMD_BEGIN_READ  = 3'd0,
        CMD_LOAD_BYTE   = 3'd1,
        CMD_BEGIN_WRITE = 3'd2,
        CMD_BUS_EVENT   = 3'd3,
        CMD_FETCH_BYTE  = 3'd4
    } t_cmd;

    // Bus actions issued to the serial interface
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_ACK   = 3'd3,
        ACT_NACK  = 3'd4,
        ACT_STOP  = 3'd5
    } t_action;

    // Master status codes, bits 7..3 of the status byte
    localparam logic [4:0] ST_START       = 5'h01;  // 0x08
    localparam logic [4:0] ST_RESTART     = 5'h02;  // 0x10
    localparam logic [4:0] ST_SLA_W_ACK   = 5'h03;  // 0x18
    localparam logic [4:0] ST_DATA_W_ACK  = 5'h05;  // 0x28
    localparam logic [4:0] ST_SLA_R_ACK   = 5'h08;  // 0x40
    localparam logic [4:0] ST_DATA_R_ACK  = 5'h0A;  // 0x50
    localparam logic [4:0] ST_DATA_R_NACK = 5'h0B;  // 0x58

    // Direction bit in the address byte
    localparam logic DIR_READ = 1'b1;

    // Total count holds the address byte plus up to 31 data bytes
    localparam int TOTAL_W = 6;

endpackage

`default_nettype wire

>>> sv/i2cmts_buffer.sv
`default_nettype none

module i2cmts_buffer #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> sv/i2c_master_transfer_sequencer_unit.sv
`default_nettype none
// Result: registered at the edge that accepts the request.
// Throughput: one request per cycle unless the result side stalls; the control state
// and buffer RAM port update at the accepting edge; requests follow back to back.
// Reset: synchronous, active low; clears busy, count, cursor, head and the output valid.
// The transfer buffer RAM is not cleared; entries read before written are undefined.

module i2c_master_transfer_sequencer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // request channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_cmd,
    input  wire logic [6:0] i_address,
    input  wire logic [4:0] i_length,
    input  wire logic [4:0] i_position,
    input  wire logic [7:0] i_data_byte,
    input  wire logic [7:0] i_bus_status,
    input  wire logic [7:0] i_bus_data,
    // result channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_accepted,
    output logic [2:0]      o_action,
    output logic [7:0]      o_tx_byte,
    output logic            o_busy_res,
    output logic [7:0]      o_rx_byte,
    output logic [6:0]      o_rx_address,
    output logic [4:0]      o_rx_length
);

    localparam int TW = i2cmts_pkg::TOTAL_W;
    // buffer index width and cursor width (cursor may reach the depth itself)
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    // common compare width for cursor, count and depth
    localparam int WW = ((CW > TW) ? CW : TW) + 1;

    // ------------------------------------------------------------------
    // Handshake: one result register; take a new request whenever the
    // register is empty or its result leaves in this cycle.
    // ------------------------------------------------------------------
    logic r_valid;
    logic w_take;

    assign o_stall = r_valid && i_stall;
    assign w_take  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic          r_busy,   n_busy;
    logic [TW-1:0] r_total,  n_total;
    logic [CW-1:0] r_cursor, n_cursor;
    // copy of buffer entry 0 (address byte); keeps the direction and address
    // readable for a fetch while the RAM port serves the data byte
    logic [7:0]    r_head,   n_head;

    // result register contents
    logic                  r_accepted,  n_accepted;
    i2cmts_pkg::t_action   r_action,    n_action;
    logic                  r_sel_tx,    n_sel_tx;
    logic                  r_sel_rx,    n_sel_rx;
    logic [6:0]            r_rx_address, n_rx_address;
    logic [4:0]            r_rx_length, n_rx_length;

    // buffer RAM port
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;

    // widened operands
    logic [WW-1:0] w_cur;
    logic [WW-1:0] w_tot;
    logic [WW-1:0] w_depth;
    logic [WW-1:0] w_len1;
    logic [WW-1:0] w_pos;
    logic [WW-1:0] w_pos1;
    logic [4:0]    w_code;
    logic          w_room;

    assign w_cur   = WW'(r_cursor);
    assign w_tot   = WW'(r_total);
    assign w_depth = WW'(BUFFER_DEPTH);
    assign w_len1  = WW'(i_length) + WW'(1);
    assign w_pos   = WW'(i_position);
    assign w_pos1  = WW'(i_position) + WW'(1);
    assign w_code  = i_bus_status[7:3];
    // space left in the buffer for a received byte
    assign w_room  = w_cur < w_depth;

    always_comb begin
        n_busy       = r_busy;
        n_total      = r_total;
        n_cursor     = r_cursor;
        n_head       = r_head;
        n_accepted   = 1'b0;
        n_action     = i2cmts_pkg::ACT_NONE;
        n_sel_tx     = 1'b0;
        n_sel_rx     = 1'b0;
        n_rx_address = '0;
        n_rx_length  = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_cursor[AW-1:0];
        w_wr_data    = i_bus_data;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_cursor[AW-1:0];

        unique case (i2cmts_pkg::t_cmd'(i_cmd))
            i2cmts_pkg::CMD_BEGIN_READ, i2cmts_pkg::CMD_BEGIN_WRITE: begin
                // refuse while busy or when the transfer would overflow the buffer
                if (!r_busy && (w_len1 <= w_depth)) begin
                    n_busy     = 1'b1;
                    n_total    = TW'(w_len1);
                    n_cursor   = '0;
                    n_head     = {i_address,
                                  (i2cmts_pkg::t_cmd'(i_cmd) == i2cmts_pkg::CMD_BEGIN_READ)
                                      ? i2cmts_pkg::DIR_READ : 1'b0};
                    w_wr_en    = 1'b1;
                    w_wr_addr  = '0;
                    w_wr_data  = n_head;
                    n_accepted = 1'b1;
                    n_action   = i2cmts_pkg::ACT_START;
                end
            end
            i2cmts_pkg::CMD_LOAD_BYTE: begin
                // data bytes live one entry above the address byte
                if (!r_busy && (w_pos1 < w_depth)) begin
                    w_wr_en    = 1'b1;
                    w_wr_addr  = w_pos1[AW-1:0];
                    w_wr_data  = i_data_byte;
                    n_accepted = 1'b1;
                end
            end
            i2cmts_pkg::CMD_BUS_EVENT: begin
                // events while idle produce nothing
                if (r_busy) begin
                    priority if (w_code == i2cmts_pkg::ST_START ||
                                 w_code == i2cmts_pkg::ST_RESTART ||
                                 w_code == i2cmts_pkg::ST_SLA_W_ACK ||
                                 w_code == i2cmts_pkg::ST_DATA_W_ACK) begin
                        // send the next byte, or stop once all are out
                        if ((w_cur < w_tot) && w_room) begin
                            w_rd_en  = 1'b1;
                            n_sel_tx = 1'b1;
                            n_cursor = r_cursor + CW'(1);
                            n_action = i2cmts_pkg::ACT_SEND;
                        end else begin
                            n_busy   = 1'b0;
                            n_action = i2cmts_pkg::ACT_STOP;
                        end
                    end else if (w_code == i2cmts_pkg::ST_DATA_R_ACK) begin
                        // store the byte, then ack unless the next one is the last
                        if (w_room) begin
                            w_wr_en  = 1'b1;
                            n_cursor = r_cursor + CW'(1);
                            if (r_cursor == CW'(0)) begin
                                n_head = i_bus_data;
                            end
                            n_action = ((w_cur + WW'(2)) < w_tot)
                                       ? i2cmts_pkg::ACT_ACK : i2cmts_pkg::ACT_NACK;
                        end else begin
                            n_action = ((w_cur + WW'(1)) < w_tot)
                                       ? i2cmts_pkg::ACT_ACK : i2cmts_pkg::ACT_NACK;
                        end
                    end else if (w_code == i2cmts_pkg::ST_SLA_R_ACK) begin
                        n_action = ((w_cur + WW'(1)) < w_tot)
                                   ? i2cmts_pkg::ACT_ACK : i2cmts_pkg::ACT_NACK;
                    end else if (w_code == i2cmts_pkg::ST_DATA_R_NACK) begin
                        // last byte of a read: store it and stop
                        if (w_room) begin
                            w_wr_en  = 1'b1;
                            n_cursor = r_cursor + CW'(1);
                            if (r_cursor == CW'(0)) begin
                                n_head = i_bus_data;
                            end
                        end
                        n_busy   = 1'b0;
                        n_action = i2cmts_pkg::ACT_STOP;
                    end else begin
                        // unknown status: drop the transfer
                        n_busy   = 1'b0;
                        n_action = i2cmts_pkg::ACT_STOP;
                    end
                end
            end
            i2cmts_pkg::CMD_FETCH_BYTE: begin
                // only after a finished read and within its length
                if (!r_busy && (r_head[0] == i2cmts_pkg::DIR_READ) &&
                    (r_total != TW'(0)) && (w_pos < (w_tot - WW'(1))) &&
                    (w_pos1 < w_depth)) begin
                    w_rd_en      = 1'b1;
                    w_rd_addr    = w_pos1[AW-1:0];
                    n_sel_rx     = 1'b1;
                    n_accepted   = 1'b1;
                    n_rx_address = r_head[7:1];
                    n_rx_length  = 5'(r_total - TW'(1));
                end
            end
            default: begin
                // unused command codes: no change
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Buffer RAM: written and read only at an accepting edge, so read
    // data holds while the result waits under stall.
    // ------------------------------------------------------------------
    i2cmts_buffer #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buffer (
        .i_clk     (i_clk),
        .i_wr_en   (w_take && w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_take && w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Advance control state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_total  <= '0;
            r_cursor <= '0;
            r_head   <= '0;
        end else if (w_take) begin
            r_busy   <= n_busy;
            r_total  <= n_total;
            r_cursor <= n_cursor;
            r_head   <= n_head;
        end
    end

    // Result valid: set on a new request, drop when taken without refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_accepted   <= n_accepted;
            r_action     <= n_action;
            r_sel_tx     <= n_sel_tx;
            r_sel_rx     <= n_sel_rx;
            r_rx_address <= n_rx_address;
            r_rx_length  <= n_rx_length;
        end
    end

    // busy after the step, kept in its own register loaded with the next busy state
    logic r_busy_res;
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_busy_res <= n_busy;
        end
    end

    assign o_valid      = r_valid;
    assign o_accepted   = r_accepted;
    assign o_action     = r_action;
    assign o_tx_byte    = r_sel_tx ? w_rd_data : 8'h00;
    assign o_busy_res   = r_busy_res;
    assign o_rx_byte    = r_sel_rx ? w_rd_data : 8'h00;
    assign o_rx_address = r_rx_address;
    assign o_rx_length  = r_rx_length;

endmodule

`default_nettype wire

>>> bench/i2cmts_tb_pkg.sv
`timescale 1ns / 1ps

package i2cmts_tb_pkg;
    import i2cmts_pkg::*;

    localparam int BUF_DEPTH = 32;

    // Command codes that the block treats as no-ops
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    // Status codes that end a transfer through the default path
    localparam logic [4:0] ST_SLA_W_NACK  = 5'h04;  // 0x20
    localparam logic [4:0] ST_DATA_W_NACK = 5'h06;  // 0x30
    localparam logic [4:0] ST_ARB_LOST    = 5'h07;  // 0x38
    localparam logic [4:0] ST_SLA_R_NACK  = 5'h09;  // 0x48
    localparam logic [4:0] ST_BUS_ERROR   = 5'h1F;  // 0xF8

    typedef struct packed {
        logic [2:0] cmd;
        logic [6:0] address;
        logic [4:0] length;
        logic [4:0] position;
        logic [7:0] data_byte;
        logic [7:0] bus_status;
        logic [7:0] bus_data;
    } request_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       busy;
        logic [7:0] rx_byte;
        logic [6:0] rx_address;
        logic [4:0] rx_length;
    } reply_t;

    class transfer_tracker;
        bit          busy;
        logic [7:0]  buffer [BUF_DEPTH];
        bit          written [BUF_DEPTH];
        int unsigned total;   // address byte plus data bytes
        int unsigned cursor;  // next entry to send or fill
        reply_t      expected_replies [$];
        int          mismatches;

        function new();
            busy       = 1'b0;
            total      = 0;
            cursor     = 0;
            mismatches = 0;
            foreach (buffer[i]) begin
                buffer[i]  = '0;
                written[i] = 1'b0;
            end
        endfunction

        function bit fetch_allowed(logic [4:0] pos);
            return !busy && buffer[0][0] == DIR_READ && total >= 1 &&
                   pos + 1 < total && pos + 1 < BUF_DEPTH;
        endfunction

        function bit sends_byte(logic [7:0] status);
            case (status[7:3])
                ST_START, ST_RESTART, ST_SLA_W_ACK, ST_DATA_W_ACK:
                    return busy && cursor < total && cursor < BUF_DEPTH;
                default:
                    return 1'b0;
            endcase
        endfunction

        // True when the request would read a buffer entry never written since reset
        function bit reads_blank(request_t r);
            if (r.cmd == CMD_FETCH_BYTE)
                return !written[0] || (fetch_allowed(r.position) && !written[r.position + 1]);
            if (r.cmd == CMD_BUS_EVENT && sends_byte(r.bus_status))
                return !written[cursor];
            return 1'b0;
        endfunction

        function void keep_rx(logic [7:0] value);
            // drop the byte once the buffer is full
            if (cursor < BUF_DEPTH) begin
                buffer[cursor]  = value;
                written[cursor] = 1'b1;
                cursor++;
            end
        endfunction

        function logic [2:0] ack_or_nack();
            return (cursor + 1 < total) ? ACT_ACK : ACT_NACK;
        endfunction

        function reply_t step_sequencer(request_t r);
            reply_t rep;
            rep = '0;
            case (r.cmd)
                CMD_BEGIN_READ, CMD_BEGIN_WRITE: begin
                    if (!busy && r.length + 1 <= BUF_DEPTH) begin
                        busy       = 1'b1;
                        buffer[0]  = {r.address,
                                      (r.cmd == CMD_BEGIN_READ) ? DIR_READ : !DIR_READ};
                        written[0] = 1'b1;
                        total      = r.length + 1;
                        cursor     = 0;
                        rep.accepted = 1'b1;
                        rep.action   = ACT_START;
                    end
                end
                CMD_LOAD_BYTE: begin
                    if (!busy && r.position + 1 < BUF_DEPTH) begin
                        buffer[r.position + 1]  = r.data_byte;
                        written[r.position + 1] = 1'b1;
                        rep.accepted = 1'b1;
                    end
                end
                CMD_BUS_EVENT: begin
                    if (busy) begin
                        case (r.bus_status[7:3])
                            ST_START, ST_RESTART, ST_SLA_W_ACK, ST_DATA_W_ACK: begin
                                if (cursor < total && cursor < BUF_DEPTH) begin
                                    rep.action  = ACT_SEND;
                                    rep.tx_byte = buffer[cursor];
                                    cursor++;
                                end else begin
                                    busy       = 1'b0;
                                    rep.action = ACT_STOP;
                                end
                            end
                            ST_DATA_R_ACK: begin
                                keep_rx(r.bus_data);
                                rep.action = ack_or_nack();
                            end
                            ST_SLA_R_ACK: begin
                                rep.action = ack_or_nack();
                            end
                            ST_DATA_R_NACK: begin
                                keep_rx(r.bus_data);
                                busy       = 1'b0;
                                rep.action = ACT_STOP;
                            end
                            default: begin
                                busy       = 1'b0;
                                rep.action = ACT_STOP;
                            end
                        endcase
                    end
                end
                CMD_FETCH_BYTE: begin
                    if (fetch_allowed(r.position)) begin
                        rep.accepted   = 1'b1;
                        rep.rx_byte    = buffer[r.position + 1];
                        rep.rx_address = buffer[0][7:1];
                        rep.rx_length  = 5'(total - 1);
                    end
                end
                default: ;
            endcase
            rep.busy = busy;
            return rep;
        endfunction

        function void note_request(request_t r);
            expected_replies.push_back(step_sequencer(r));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t: mismatch: %s", $time, what);
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("result with no request pending, action %0d",
                                          got.action));
                return;
            end
            want = expected_replies.pop_front();
            compare_field("accepted", got.accepted, want.accepted);
            compare_field("action", got.action, want.action);
            compare_field("tx_byte", got.tx_byte, want.tx_byte);
            compare_field("busy", got.busy, want.busy);
            compare_field("rx_byte", got.rx_byte, want.rx_byte);
            compare_field("rx_address", got.rx_address, want.rx_address);
            compare_field("rx_length", got.rx_length, want.rx_length);
        endtask
    endclass

endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2cmts_pkg::*;
    import i2cmts_tb_pkg::*;

    localparam int STALL_PCT   = 14;
    localparam int QUIET_LIMIT = 5000;
    localparam int ITEM_TARGET = 850;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_stall;
    logic [2:0] i_cmd        = '0;
    logic [6:0] i_address    = '0;
    logic [4:0] i_length     = '0;
    logic [4:0] i_position   = '0;
    logic [7:0] i_data_byte  = '0;
    logic [7:0] i_bus_status = '0;
    logic [7:0] i_bus_data   = '0;
    logic       o_valid;
    logic       i_stall      = 1'b0;
    logic       o_accepted;
    logic [2:0] o_action;
    logic [7:0] o_tx_byte;
    logic       o_busy_res;
    logic [7:0] o_rx_byte;
    logic [6:0] o_rx_address;
    logic [4:0] o_rx_length;

    transfer_tracker tracker = new();

    bit          steady       = 1'b0;  // no idling on either side while set
    bit          drained      = 1'b0;
    int unsigned sent_count   = 0;
    int unsigned quiet_cycles = 0;

    i2c_master_transfer_sequencer_unit #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_address    (i_address),
        .i_length     (i_length),
        .i_position   (i_position),
        .i_data_byte  (i_data_byte),
        .i_bus_status (i_bus_status),
        .i_bus_data   (i_bus_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_accepted   (o_accepted),
        .o_action     (o_action),
        .o_tx_byte    (o_tx_byte),
        .o_busy_res   (o_busy_res),
        .o_rx_byte    (o_rx_byte),
        .o_rx_address (o_rx_address),
        .o_rx_length  (o_rx_length)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[i2c_master_transfer_sequencer_unit] ERROR");
            $finish;
        end
    end

    // Result side: check each accepted result, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_reply(reply_t'{accepted: o_accepted, action: o_action,
                                         tx_byte: o_tx_byte, busy: o_busy_res,
                                         rx_byte: o_rx_byte, rx_address: o_rx_address,
                                         rx_length: o_rx_length});
        i_stall <= i_rst_n && !steady && ($urandom_range(99) < STALL_PCT);
    end

    // Fill every field with random content; callers overwrite what matters
    function automatic request_t random_request(logic [2:0] cmd);
        request_t r;
        r.cmd        = cmd;
        r.address    = 7'($urandom);
        r.length     = 5'($urandom);
        r.position   = 5'($urandom);
        r.data_byte  = 8'($urandom);
        r.bus_status = 8'($urandom);
        r.bus_data   = 8'($urandom);
        return r;
    endfunction

    // Mostly short transfers, now and then up to the full buffer
    function automatic logic [4:0] pick_length();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(6));
    endfunction

    // Drive one request and return at the edge that accepts it. The caller
    // must follow up in the same step with another request or a drop of valid.
    task automatic send_request(request_t r);
        // divert anything that would read a buffer entry never written
        if (tracker.reads_blank(r)) begin
            if (r.cmd == CMD_FETCH_BYTE)
                r.cmd = CMD_SPARE_FIRST;
            else
                r.bus_status = {ST_ARB_LOST, r.bus_status[2:0]};
        end
        // idle the request channel now and then
        while (!steady && $urandom_range(99) < STALL_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= r.cmd;
        i_address    <= r.address;
        i_length     <= r.length;
        i_position   <= r.position;
        i_data_byte  <= r.data_byte;
        i_bus_status <= r.bus_status;
        i_bus_data   <= r.bus_data;
        // hold the payload until the block takes it
        do @(posedge i_clk); while (o_stall);
        tracker.note_request(r);
        sent_count++;
    endtask

    task automatic load_byte(logic [4:0] pos, logic [7:0] value);
        request_t r;
        r           = random_request(CMD_LOAD_BYTE);
        r.position  = pos;
        r.data_byte = value;
        send_request(r);
    endtask

    task automatic begin_transfer(logic [2:0] cmd, logic [6:0] addr, logic [4:0] len);
        request_t r;
        r         = random_request(cmd);
        r.address = addr;
        r.length  = len;
        send_request(r);
    endtask

    task automatic bus_event(logic [4:0] code);
        request_t r;
        r            = random_request(CMD_BUS_EVENT);
        r.bus_status = {code, r.bus_status[2:0]};
        send_request(r);
    endtask

    task automatic fetch_byte(logic [4:0] pos);
        request_t r;
        r          = random_request(CMD_FETCH_BYTE);
        r.position = pos;
        send_request(r);
    endtask

    // Load the data, start a write and walk the bus through it, with the odd
    // refused begin, ignored load or early nack thrown in
    task automatic write_transfer(logic [4:0] len);
        if (tracker.busy)
            bus_event(ST_BUS_ERROR);
        for (int p = 0; p < len; p++)
            load_byte(5'(p), 8'($urandom));
        begin_transfer(CMD_BEGIN_WRITE, 7'($urandom), len);
        bus_event(($urandom_range(3) == 0) ? ST_RESTART : ST_START);
        bus_event(($urandom_range(15) == 0) ? ST_SLA_W_NACK : ST_SLA_W_ACK);
        while (tracker.busy) begin
            case ($urandom_range(19))
                0: bus_event(ST_DATA_W_NACK);
                1: begin_transfer($urandom_range(1) ? CMD_BEGIN_READ : CMD_BEGIN_WRITE,
                                  7'($urandom), pick_length());
                2: load_byte(5'($urandom), 8'($urandom));
                default: bus_event(ST_DATA_W_ACK);
            endcase
        end
    endtask

    // Start a read, answer the way a slave would, then fetch some bytes back.
    // Extra data events past the last byte push the cursor past the read length, at most to the buffer end.
    task automatic read_transfer(logic [4:0] len, int extra);
        int overrun;
        overrun = extra;
        if (tracker.busy)
            bus_event(ST_BUS_ERROR);
        begin_transfer(CMD_BEGIN_READ, 7'($urandom), len);
        bus_event(ST_START);
        bus_event(($urandom_range(15) == 0) ? ST_SLA_R_NACK : ST_SLA_R_ACK);
        while (tracker.busy) begin
            if ($urandom_range(9) == 0)
                fetch_byte(5'($urandom));
            else if (tracker.cursor + 1 < tracker.total)
                bus_event(ST_DATA_R_ACK);
            else if (overrun > 0) begin
                overrun--;
                bus_event(ST_DATA_R_ACK);
            end else
                bus_event(ST_DATA_R_NACK);
        end
        repeat ($urandom_range(1, 4))
            fetch_byte(($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(len)));
    endtask

    // Short run of unrelated requests, unused command codes included
    task automatic noise_burst();
        repeat ($urandom_range(1, 4))
            send_request(random_request(3'($urandom)));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part
        bus_event(ST_START);                           // event while idle
        send_request(random_request(CMD_SPARE_FIRST));
        send_request(random_request(CMD_SPARE_LAST));
        load_byte(5'd0, 8'h00);
        load_byte(5'd30, 8'hFF);
        load_byte(5'd31, 8'hA5);                       // past the buffer end
        begin_transfer(CMD_BEGIN_WRITE, 7'h7F, 5'd1);
        begin_transfer(CMD_BEGIN_READ, 7'h00, 5'd0);   // refused while busy
        load_byte(5'd1, 8'h3C);                        // ignored while busy
        fetch_byte(5'd0);                              // refused while busy
        bus_event(ST_START);
        bus_event(ST_SLA_W_ACK);
        bus_event(ST_DATA_W_ACK);                      // nothing left, stop
        begin_transfer(CMD_BEGIN_READ, 7'h00, 5'd0);
        bus_event(ST_START);
        bus_event(ST_SLA_R_ACK);                       // zero-length read, nack
        bus_event(ST_DATA_R_NACK);
        fetch_byte(5'd0);
        fetch_byte(5'd1);                              // beyond the read length
        begin_transfer(CMD_BEGIN_WRITE, 7'h55, 5'd0);
        bus_event(ST_BUS_ERROR);                       // unknown status code
        fetch_byte(5'd0);                              // last transfer was a write

        // Random part, opened by a full-buffer read that overruns the buffer
        read_transfer(5'd31, 2);
        while (sent_count < ITEM_TARGET) begin
            steady <= (sent_count >= 500 && sent_count < 650);
            if (!drained && sent_count >= ITEM_TARGET / 2) begin
                // hold off until every pending result has come back
                drained = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (tracker.expected_replies.size() != 0);
            end
            case ($urandom_range(9))
                0, 1: noise_burst();
                2, 3, 4, 5: write_transfer(pick_length());
                default: read_transfer(pick_length(),
                                       ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0);
            endcase
        end

        // Drain and settle
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_replies.size() != 0);
        repeat (4) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0)
            $display("[i2c_master_transfer_sequencer_unit] OK");
        else
            $display("[i2c_master_transfer_sequencer_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
sv/i2cmts_pkg.sv
sv/i2cmts_buffer.sv
sv/i2c_master_transfer_sequencer_unit.sv
bench/i2cmts_tb_pkg.sv
bench/tb.sv
